/* hw/rtl/b2s_pkg.sv */
`default_nettype none
package b2s_pkg;

  localparam int unsigned ROUNDS     = 10;
  localparam int unsigned HALF_STEPS = ROUNDS * 16;
  localparam logic [7:0]  LastStep   = 8'(HALF_STEPS);

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] PARAM_BASE  = 32'h01010000;
  localparam logic [5:0]  DLEN_RESET  = 6'd32;

  // Message word schedule, one entry per half mixing step, round by round
  localparam logic [3:0] SIGMA [HALF_STEPS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
    4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3,
    4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
    4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4,
    4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
    4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8,
    4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
    4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13,
    4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
    4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9,
    4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
    4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11,
    4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
    4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10,
    4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
    4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5,
    4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
    4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0
  };

  // Working vector indices {a, b, c, d} for each of the eight mixes of a round
  localparam logic [15:0] G_IDX [8] = '{
    16'h048C, 16'h159D, 16'h26AE, 16'h37BF,
    16'h05AF, 16'h16BC, 16'h278D, 16'h349E
  };

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       init;
    logic       final_blk;
    logic       rd;
    logic [3:0] rd_addr;
    logic       step;
    logic [3:0] step_pos;
    logic       fold;
    logic       restart;
  } b2s_cmd_t;

  typedef struct packed {
    logic has_bytes;
    logic last;
    logic full;
  } b2s_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/b2s_dp.sv */
`default_nettype none
module b2s_dp import b2s_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire b2s_cmd_t    cmd_i,
  input  wire logic [39:0] item_data_i,
  input  wire logic        item_last_i,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic [2:0]  out_idx_i,
  output b2s_stat_t        stat_o,
  output logic [31:0]      digest_o
);

  logic [31:0] h_q [8];
  logic [31:0] v_q [16];
  logic [31:0] mem [16];
  logic [63:0] t_q;
  logic [6:0]  buf_q;
  logic [5:0]  dlen_q;
  logic [31:0] item_word_q;
  logic [2:0]  item_cnt_q;
  logic        item_last_q;
  logic [31:0] rd_data_q;
  logic        rd_zero_q;

  logic [2:0]  in_cnt, eff_cnt;
  logic [31:0] in_masked;
  logic [6:0]  fill_sum;
  logic [4:0]  fill_words;
  logic [63:0] t_next;
  logic        msg_empty;
  logic [31:0] m_word;
  logic [3:0]  ia, ib, ic, id;
  logic [31:0] a1, b1, c1, d1, dx, bx;

  function automatic logic [31:0] h_init(input int unsigned i, input logic [5:0] dl);
    h_init = (i == 0) ? (IV[i] ^ PARAM_BASE ^ {26'd0, dl}) : IV[i];
  endfunction

  // Short count only counts at end of message; above four counts as four
  always_comb begin
    in_cnt  = item_data_i[34:32];
    eff_cnt = (!item_last_i || in_cnt > 3'd4) ? 3'd4 : in_cnt;
    for (int i = 0; i < 4; i++) begin
      in_masked[8*i +: 8] = (3'(i) < eff_cnt) ? item_data_i[8*i +: 8] : 8'd0;
    end
  end

  assign fill_sum   = buf_q + 7'd3;
  assign fill_words = fill_sum[6:2];
  assign t_next     = t_q + {57'd0, buf_q};
  assign msg_empty  = (buf_q == 7'd0) && (t_q == 64'd0);
  assign m_word     = rd_zero_q ? 32'd0 : rd_data_q;

  assign stat_o.has_bytes = (item_cnt_q != 3'd0);
  assign stat_o.last      = item_last_q;
  assign stat_o.full      = buf_q[6];
  assign digest_o         = h_q[out_idx_i];

  always_comb begin
    ia = G_IDX[cmd_i.step_pos[3:1]][15:12];
    ib = G_IDX[cmd_i.step_pos[3:1]][11:8];
    ic = G_IDX[cmd_i.step_pos[3:1]][7:4];
    id = G_IDX[cmd_i.step_pos[3:1]][3:0];
    a1 = v_q[ia] + v_q[ib] + m_word;
    dx = v_q[id] ^ a1;
    d1 = cmd_i.step_pos[0] ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    c1 = v_q[ic] + d1;
    bx = v_q[ib] ^ c1;
    b1 = cmd_i.step_pos[0] ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_init(i, DLEN_RESET);
      t_q    <= 64'd0;
      buf_q  <= 7'd0;
      dlen_q <= DLEN_RESET;
    end else begin
      if (cfg_we_i) begin
        dlen_q <= cfg_wdata_i;
        if (msg_empty) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_init(i, cfg_wdata_i);
        end
      end
      if (cmd_i.wr && stat_o.has_bytes) buf_q <= buf_q + {4'd0, item_cnt_q};
      if (cmd_i.init) t_q <= t_next;
      if (cmd_i.fold) begin
        buf_q <= 7'd0;
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
      end
      if (cmd_i.restart) begin
        t_q   <= 64'd0;
        buf_q <= 7'd0;
        for (int i = 0; i < 8; i++) h_q[i] <= h_init(i, dlen_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_word_q <= in_masked;
      item_cnt_q  <= eff_cnt;
      item_last_q <= item_last_i;
    end
    if (cmd_i.wr && stat_o.has_bytes) mem[buf_q[5:2]] <= item_word_q;
    // Words past the fill count read as zero padding
    if (cmd_i.rd) begin
      rd_data_q <= mem[cmd_i.rd_addr];
      rd_zero_q <= ({1'b0, cmd_i.rd_addr} >= fill_words);
    end
    if (cmd_i.init) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i]   <= h_q[i];
        v_q[i+8] <= IV[i];
      end
      v_q[12] <= IV[4] ^ t_next[31:0];
      v_q[13] <= IV[5] ^ t_next[63:32];
      v_q[14] <= cmd_i.final_blk ? ~IV[6] : IV[6];
    end else if (cmd_i.step) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) == ia) v_q[i] <= a1;
        if (4'(i) == ib) v_q[i] <= b1;
        if (4'(i) == ic) v_q[i] <= c1;
        if (4'(i) == id) v_q[i] <= d1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/b2s_ctrl.sv */
`default_nettype none
module b2s_ctrl import b2s_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire b2s_stat_t  stat_i,
  output b2s_cmd_t        cmd_o,
  output logic [2:0]      out_idx_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WRITE, ST_INIT, ST_RUN, ST_FOLD, ST_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] cnt_q;
  logic       final_q;
  logic       step_q;
  logic [3:0] pos_q;
  logic [2:0] out_idx_q;
  logic       in_acc, out_acc, mid_blk, rd_go;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_idx_o   = out_idx_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  // A full block is compressed on more bytes or message end
  assign mid_blk     = stat_i.has_bytes && stat_i.full;
  assign rd_go       = (state_q == ST_RUN) && (cnt_q != LastStep);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_acc;
    cmd_o.wr        = (state_q == ST_WRITE) && !mid_blk;
    cmd_o.init      = (state_q == ST_INIT);
    cmd_o.final_blk = final_q;
    cmd_o.rd        = rd_go;
    cmd_o.rd_addr   = rd_go ? SIGMA[cnt_q] : 4'd0;
    cmd_o.step      = step_q;
    cmd_o.step_pos  = pos_q;
    cmd_o.fold      = (state_q == ST_FOLD);
    cmd_o.restart   = out_acc && (out_idx_q == 3'd7);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_WRITE;
      ST_WRITE: begin
        if (mid_blk || stat_i.last) state_d = ST_INIT;
        else                        state_d = ST_IDLE;
      end
      ST_INIT:  state_d = ST_RUN;
      ST_RUN:   if (cnt_q == LastStep) state_d = ST_FOLD;
      ST_FOLD:  state_d = final_q ? ST_OUT : ST_WRITE;
      ST_OUT:   if (cmd_o.restart) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= 8'd0;
      final_q   <= 1'b0;
      step_q    <= 1'b0;
      pos_q     <= 4'd0;
      out_idx_q <= 3'd0;
    end else begin
      state_q <= state_d;
      step_q  <= rd_go;
      pos_q   <= cnt_q[3:0];
      if (state_q == ST_WRITE) final_q <= !mid_blk && stat_i.last;
      if (state_q == ST_INIT) cnt_q <= 8'd0;
      else if (rd_go)         cnt_q <= cnt_q + 8'd1;
      if (out_acc) out_idx_q <= out_idx_q + 3'd1;
    end
  end

  a_step_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q |-> (state_q == ST_RUN))
    else $error("mixing step outside compression");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr && stat_i.has_bytes) |-> !stat_i.full)
    else $error("write into a full block buffer");

  a_fold_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD) |=> (state_q == ST_OUT || state_q == ST_WRITE))
    else $error("bad state after fold");

  a_out_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_idx_q == 3'd0))
    else $error("digest output does not start at word zero");

endmodule
`default_nettype wire

/* hw/rtl/blake2s_stream_hasher_top.sv */
// Channel   Dir  tdata (low bit up)                     tlast           tuser
// s_*       in   msg_word[31:0] byte_count[34:32] 0s    end_of_message  -
// m_*       out  digest_word[31:0] word_index[34:32] 0s last_word       -
// cfg_*     in   digest_length[5:0]                     -               -
//
// A word is accepted and written, plus one compression when it finds a full
// block waiting. Each compression runs one half mixing step per cycle on a
// single adder chain: 160 steps fed by one registered read of the block
// buffer memory. A final word adds its compression and the eight digest words.
// Reset loads the chain value from IV and digest_length 32; no clearing pass.
// The digest holds input until all eight words have been taken.
`default_nettype none
module blake2s_stream_hasher_top import b2s_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // msg_word, byte_count, zero fill
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // digest_word, word_index, zero fill
  output logic             m_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i
);

  b2s_cmd_t    cmd;
  b2s_stat_t   stat;
  logic [2:0]  out_idx;
  logic [31:0] digest;

  b2s_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .out_idx_o   (out_idx)
  );

  b2s_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_data_i (s_tdata),
    .item_last_i (s_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_idx_i   (out_idx),
    .stat_o      (stat),
    .digest_o    (digest)
  );

  assign m_tdata = {5'd0, out_idx, digest};
  assign m_tlast = (out_idx == 3'd7);

endmodule
`default_nettype wire

/* tb/tb_blake2s_stream_hasher_top.sv */
`default_nettype none
module tb_blake2s_stream_hasher_top import b2s_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        eom;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  localparam int HoldCycles = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;

  blake2s_stream_hasher_top DUT (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [5:0]  dlen;
  logic [31:0] hstate [8];
  logic [31:0] blk [16];
  int unsigned nbuf;
  logic [63:0] nbytes_total;

  msg_item_t    msg_q [$];
  digest_item_t digest_q [$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_cnt = 0;
  logic         hold_go = 1'b0;
  logic         hold_used = 1'b0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic fresh_message();
    for (int i = 0; i < 8; i++) hstate[i] = IV[i];
    hstate[0] ^= PARAM_BASE ^ {26'd0, dlen};
    for (int i = 0; i < 16; i++) blk[i] = '0;
    nbuf = 0;
    nbytes_total = '0;
  endtask

  task automatic mixg(inout logic [31:0] v [16], input int a, int b, int c, int d,
                      input logic [31:0] x, logic [31:0] y);
    v[a] = v[a] + v[b] + x;
    v[d] = rotr(v[d] ^ v[a], 16);
    v[c] = v[c] + v[d];
    v[b] = rotr(v[b] ^ v[c], 12);
    v[a] = v[a] + v[b] + y;
    v[d] = rotr(v[d] ^ v[a], 8);
    v[c] = v[c] + v[d];
    v[b] = rotr(v[b] ^ v[c], 7);
  endtask

  task automatic compress_block(logic fin);
    logic [31:0] v [16];
    int s;
    for (int i = 0; i < 8; i++) begin
      v[i] = hstate[i];
      v[i + 8] = IV[i];
    end
    v[12] ^= nbytes_total[31:0];
    v[13] ^= nbytes_total[63:32];
    if (fin) v[14] = ~v[14];
    for (int r = 0; r < 10; r++) begin
      s = r * 16;
      mixg(v, 0, 4, 8, 12, blk[SIGMA[s]], blk[SIGMA[s + 1]]);
      mixg(v, 1, 5, 9, 13, blk[SIGMA[s + 2]], blk[SIGMA[s + 3]]);
      mixg(v, 2, 6, 10, 14, blk[SIGMA[s + 4]], blk[SIGMA[s + 5]]);
      mixg(v, 3, 7, 11, 15, blk[SIGMA[s + 6]], blk[SIGMA[s + 7]]);
      mixg(v, 0, 5, 10, 15, blk[SIGMA[s + 8]], blk[SIGMA[s + 9]]);
      mixg(v, 1, 6, 11, 12, blk[SIGMA[s + 10]], blk[SIGMA[s + 11]]);
      mixg(v, 2, 7, 8, 13, blk[SIGMA[s + 12]], blk[SIGMA[s + 13]]);
      mixg(v, 3, 4, 9, 14, blk[SIGMA[s + 14]], blk[SIGMA[s + 15]]);
    end
    for (int i = 0; i < 8; i++) hstate[i] ^= v[i] ^ v[i + 8];
  endtask

  task automatic absorb_word(msg_item_t it);
    int unsigned cnt;
    logic [31:0] w;
    cnt = it.nbytes;
    w = it.word;
    if (cnt > 4 || !it.eom) cnt = 4;
    if (cnt > 0) begin
      if (nbuf >= 64) begin
        nbytes_total += 64;
        compress_block(1'b0);
        for (int i = 0; i < 16; i++) blk[i] = '0;
        nbuf = 0;
      end
      if (cnt < 4) w &= (32'd1 << (8 * cnt)) - 1;
      blk[(nbuf >> 2) & 15] = w;
      nbuf += cnt;
    end
    if (it.eom) begin
      nbytes_total += nbuf;
      for (int k = (nbuf + 3) >> 2; k < 16; k++) blk[k] = '0;
      compress_block(1'b1);
      for (int k = 0; k < 8; k++) digest_q.push_back('{hstate[k], 3'(k), k == 7});
      fresh_message();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        absorb_word(msg_q.pop_front());
      end
      if ((!s_tvalid || s_tready) || !s_tvalid) begin
        if (s_tvalid && s_tready || !s_tvalid) begin
          if (msg_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata <= {5'd0, msg_q[0].nbytes, msg_q[0].word};
            s_tlast <= msg_q[0].eom;
          end else begin
            s_tvalid <= 1'b0;
          end
        end
      end
    end
  end

  // Receiver hold-off: count down a long stall once it is requested
  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_cnt  <= HoldCycles;
      hold_used <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    digest_item_t exp_d;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest word", m_tdata[31:0], 32'd0);
        end else begin
          exp_d = digest_q.pop_front();
          if (m_tdata[31:0] !== exp_d.word) report_mismatch("digest_word", m_tdata[31:0], exp_d.word);
          if (m_tdata[34:32] !== exp_d.idx) report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(exp_d.idx));
          if (m_tdata[39:35] !== 5'd0) report_mismatch("tdata fill", 32'(m_tdata[39:35]), 32'd0);
          if (m_tlast !== exp_d.last) report_mismatch("last_word", 32'(m_tlast), 32'(exp_d.last));
        end
      end
      if (hold_cnt > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_message(int nwords, int last_cnt);
    msg_item_t it;
    for (int i = 0; i < nwords; i++) begin
      it.word = $urandom();
      it.eom = (i == nwords - 1);
      it.nbytes = it.eom ? 3'(last_cnt) : (($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4);
      msg_q.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (msg_q.size() > 0 || s_tvalid || digest_q.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_dlen(logic [5:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dlen = val;
    if (nbuf == 0 && nbytes_total == 0) fresh_message();
  endtask

  task automatic queue_random_messages(int nitems);
    int n;
    n = 0;
    while (n < nitems) begin
      if ($urandom_range(9) == 0) begin
        queue_message($urandom_range(1, 3), $urandom_range(7));
        n += 3;
      end else begin
        queue_message($urandom_range(1, 40), $urandom_range(0, 4));
        n += 20;
      end
    end
  endtask

  initial begin
    msg_item_t it;
    dlen = DLEN_RESET;
    fresh_message();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty message, extremes, short words mid-message, full-block edges
    it = '{32'hFFFFFFFF, 3'd0, 1'b1}; msg_q.push_back(it);
    it = '{32'hFFFFFFFF, 3'd1, 1'b0}; msg_q.push_back(it);
    it = '{32'h00000000, 3'd7, 1'b0}; msg_q.push_back(it);
    it = '{32'hA5A5A5A5, 3'd3, 1'b1}; msg_q.push_back(it);
    it = '{32'h12345678, 3'd6, 1'b1}; msg_q.push_back(it);
    queue_message(16, 0);
    queue_message(16, 4);
    wait_drained();

    write_dlen(6'd1);
    queue_message(3, 2);
    wait_drained();
    write_dlen(6'd0);
    queue_message(17, 1);
    wait_drained();
    write_dlen(6'd63);
    queue_message(2, 5);
    wait_drained();
    write_dlen(6'd32);

    send_idle_pct = 18; recv_idle_pct = 54;
    queue_random_messages(50);
    wait_drained();
    write_dlen(6'($urandom_range(1, 32)));

    send_idle_pct = 54; recv_idle_pct = 18;
    // Long receiver hold-off while messages keep coming
    hold_go = 1'b1;
    queue_random_messages(50);
    wait_drained();
    write_dlen(6'($urandom_range(63)));

    send_idle_pct = 0; recv_idle_pct = 0;
    queue_random_messages(50);
    wait_drained();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/b2s_pkg.sv
hw/rtl/b2s_dp.sv
hw/rtl/b2s_ctrl.sv
hw/rtl/blake2s_stream_hasher_top.sv
tb/tb_blake2s_stream_hasher_top.sv
